### design/call_stack_exclusive_time_macros.svh
// Assertion macros shared by the call stack exclusive time design.
`ifndef CALL_STACK_EXCLUSIVE_TIME_MACROS_SVH
`define CALL_STACK_EXCLUSIVE_TIME_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CSET_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Check that a condition is followed by a result on the next edge.
`define CSET_ASSERT_NEXT(lbl, cond, res, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (res)) \
	else $error(msg);

`endif

### design/cset_pkg.sv
// Types, codes and helpers shared by the call stack exclusive time design.
package cset_pkg;

	localparam int NUM_FUNCS_DEF   = 64;
	localparam int STACK_DEPTH_DEF = 32;
	localparam int FID_W           = 6;
	localparam int TS_W            = 32;
	localparam int QUEUE_DEPTH     = 2;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_END   = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		CMD_NONE = 2'd0,
		CMD_PUSH = 2'd1,
		CMD_POP  = 2'd2,
		CMD_READ = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		status_t           status;
		logic [FID_W-1:0]  fid;
		logic [TS_W-1:0]   ts;
		logic              in_range;
		logic              has_parent;
	} cmd_t;

	typedef enum logic [2:0] {
		B_CLEAR,
		B_IDLE,
		B_DUR,
		B_EXC,
		B_TOT,
		B_OUT
	} back_state_t;

	function automatic logic [TS_W-1:0] sat_add(input logic [TS_W-1:0] a,
		input logic [TS_W-1:0] b);
		logic [TS_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TS_W] ? {TS_W{1'b1}} : s[TS_W-1:0];
	endfunction

endpackage

### design/cset_front.sv
// Front end: accepts trace words, tracks the stack level and classifies each event.
`include "call_stack_exclusive_time_macros.svh"

module cset_front #(
	parameter int NUM_FUNCS   = cset_pkg::NUM_FUNCS_DEF,
	parameter int STACK_DEPTH = cset_pkg::STACK_DEPTH_DEF,
	localparam int SA = $clog2(STACK_DEPTH),
	localparam int LW = $clog2(STACK_DEPTH + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic [cset_pkg::FID_W-1:0]  function_id,
	input  logic [cset_pkg::TS_W-1:0]   timestamp,
	input  logic                        q_full,
	input  logic                        clearing,
	output logic                        q_push,
	output cset_pkg::cmd_t              cmd,
	output logic [SA-1:0]               idx
);

	logic [LW-1:0] level_q;
	logic [LW-1:0] level_d;
	logic          accept;

	assign in_stall = q_full || clearing;
	assign accept   = in_valid && !in_stall;
	assign q_push   = accept;

	always_comb begin
		cmd.kind       = cset_pkg::CMD_NONE;
		cmd.status     = cset_pkg::ST_OK;
		cmd.fid        = function_id;
		cmd.ts         = timestamp;
		cmd.in_range   = (32'(function_id) < 32'(NUM_FUNCS));
		cmd.has_parent = 1'b0;
		idx            = '0;
		level_d        = level_q;
		unique case (operation)
			cset_pkg::OP_START: begin
				if (level_q == LW'(STACK_DEPTH)) begin
					cmd.status = cset_pkg::ST_FULL;
				end else begin
					cmd.kind = cset_pkg::CMD_PUSH;
					idx      = SA'(level_q);
					level_d  = level_q + LW'(1);
				end
			end
			cset_pkg::OP_END: begin
				if (level_q == '0) begin
					// empty stack still reports the current total
					cmd.kind   = cset_pkg::CMD_READ;
					cmd.status = cset_pkg::ST_EMPTY;
				end else begin
					cmd.kind       = cset_pkg::CMD_POP;
					cmd.has_parent = (level_q > LW'(1));
					idx            = SA'(level_q - LW'(1));
					level_d        = level_q - LW'(1);
				end
			end
			cset_pkg::OP_READ: begin
				cmd.kind = cset_pkg::CMD_READ;
			end
			default: begin
				cmd.kind = cset_pkg::CMD_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
		end else if (accept) begin
			level_q <= level_d;
		end
	end

	`CSET_ASSERT(a_level_bound, level_q <= LW'(STACK_DEPTH), "stack level above depth")
	`CSET_ASSERT_NEXT(a_full_holds, accept && cmd.status == cset_pkg::ST_FULL,
		$stable(level_q), "full start moved the stack level")
	`CSET_ASSERT_NEXT(a_pop_drops, accept && cmd.kind == cset_pkg::CMD_POP,
		level_q == $past(level_q) - LW'(1), "end did not drop the stack level")

endmodule

### design/cset_queue.sv
// Short queue of classified commands between the front and back ends.
module cset_queue #(
	parameter int WIDTH = 8,
	localparam int QA = $clog2(cset_pkg::QUEUE_DEPTH)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	logic [WIDTH-1:0] mem_q [cset_pkg::QUEUE_DEPTH];
	logic [QA-1:0]    wr_ptr_q;
	logic [QA-1:0]    rd_ptr_q;
	logic [QA:0]      count_q;

	assign full  = (count_q == (QA+1)'(cset_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QA'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QA'(1);
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + (QA+1)'(1);
				2'b01:   count_q <= count_q - (QA+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### design/cset_back.sv
// Back end: stack and total memories, close arithmetic and the result register.
`include "call_stack_exclusive_time_macros.svh"

module cset_back #(
	parameter int NUM_FUNCS   = cset_pkg::NUM_FUNCS_DEF,
	parameter int STACK_DEPTH = cset_pkg::STACK_DEPTH_DEF,
	localparam int SA = $clog2(STACK_DEPTH),
	localparam int FA = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cset_pkg::cmd_t              q_cmd,
	input  logic [SA-1:0]               q_idx,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic                        clearing,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [cset_pkg::FID_W-1:0]  function_out,
	output logic [cset_pkg::TS_W-1:0]   interval_time,
	output logic [cset_pkg::TS_W-1:0]   total_time
);

	localparam int TW = cset_pkg::TS_W;

	cset_pkg::back_state_t state_q, state_d;

	logic [TW-1:0] start_mem  [STACK_DEPTH];
	logic [TW-1:0] nested_mem [STACK_DEPTH];
	logic [TW-1:0] total_mem  [NUM_FUNCS];

	cset_pkg::cmd_t cmd_q;
	logic [SA-1:0]  idx_q;
	logic [TW-1:0]  start_rd_q, nest_rd_q, parent_rd_q, total_rd_q;
	logic [TW-1:0]  dur_q, interval_q, total_q;
	logic [FA-1:0]  clr_cnt_q;
	logic           out_valid_q;

	logic          out_load;
	logic          nest_we, tot_we;
	logic [SA-1:0] nest_wa;
	logic [TW-1:0] nest_wd;
	logic [FA-1:0] tot_wa;
	logic [TW-1:0] tot_wd;
	logic [TW:0]   diff;
	logic [TW-1:0] dur_d, interval_d, total_new, parent_new;
	logic [TW-1:0] res_interval, res_total;

	assign clearing = (state_q == cset_pkg::B_CLEAR);
	assign q_pop    = (state_q == cset_pkg::B_IDLE) && !q_empty;
	assign out_load = (state_q == cset_pkg::B_OUT) && (!out_valid_q || !out_stall);

	// close arithmetic: duration, exclusive time, caller update and total update
	assign diff       = {1'b0, cmd_q.ts} - {1'b0, start_rd_q};
	assign dur_d      = diff[TW] ? '0 : cset_pkg::sat_add(diff[TW-1:0], TW'(1));
	assign interval_d = (dur_q >= nest_rd_q) ? dur_q - nest_rd_q : '0;
	assign parent_new = cset_pkg::sat_add(parent_rd_q, dur_q);
	assign total_new  = cset_pkg::sat_add(total_rd_q, interval_q);

	always_comb begin
		state_d = state_q;
		nest_we = 1'b0;
		nest_wa = q_idx;
		nest_wd = '0;
		tot_we  = 1'b0;
		tot_wa  = clr_cnt_q;
		tot_wd  = '0;
		unique case (state_q)
			cset_pkg::B_CLEAR: begin
				tot_we = 1'b1;
				if (clr_cnt_q == FA'(NUM_FUNCS - 1)) begin
					state_d = cset_pkg::B_IDLE;
				end
			end
			cset_pkg::B_IDLE: begin
				if (q_pop) begin
					if (q_cmd.kind == cset_pkg::CMD_PUSH) begin
						nest_we = 1'b1;
					end
					state_d = (q_cmd.kind == cset_pkg::CMD_POP) ? cset_pkg::B_DUR
						: cset_pkg::B_OUT;
				end
			end
			cset_pkg::B_DUR: begin
				state_d = cset_pkg::B_EXC;
			end
			cset_pkg::B_EXC: begin
				// fold the closed call into its caller's nested time
				nest_we = cmd_q.has_parent;
				nest_wa = idx_q - SA'(1);
				nest_wd = parent_new;
				state_d = cset_pkg::B_TOT;
			end
			cset_pkg::B_TOT: begin
				tot_we  = cmd_q.in_range;
				tot_wa  = FA'(cmd_q.fid);
				tot_wd  = total_new;
				state_d = cset_pkg::B_OUT;
			end
			cset_pkg::B_OUT: begin
				if (out_load) begin
					state_d = cset_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = cset_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= cset_pkg::B_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cset_pkg::B_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + FA'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.kind == cset_pkg::CMD_PUSH) begin
			start_mem[q_idx] <= q_cmd.ts;
		end
		if (q_pop) begin
			start_rd_q <= start_mem[q_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (nest_we) begin
			nested_mem[nest_wa] <= nest_wd;
		end
		if (q_pop) begin
			nest_rd_q   <= nested_mem[q_idx];
			parent_rd_q <= nested_mem[q_idx - SA'(1)];
		end
	end

	always_ff @(posedge clk) begin
		if (tot_we) begin
			total_mem[tot_wa] <= tot_wd;
		end
		if (q_pop) begin
			total_rd_q <= total_mem[FA'(q_cmd.fid)];
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
			idx_q <= q_idx;
		end
		if (state_q == cset_pkg::B_DUR) begin
			dur_q <= dur_d;
		end
		if (state_q == cset_pkg::B_EXC) begin
			interval_q <= interval_d;
		end
		if (state_q == cset_pkg::B_TOT) begin
			total_q <= cmd_q.in_range ? total_new : '0;
		end
	end

	always_comb begin
		res_interval = (cmd_q.kind == cset_pkg::CMD_POP) ? interval_q : '0;
		unique case (cmd_q.kind)
			cset_pkg::CMD_POP:  res_total = total_q;
			cset_pkg::CMD_READ: res_total = cmd_q.in_range ? total_rd_q : '0;
			default:            res_total = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			status        <= cmd_q.status;
			function_out  <= cmd_q.fid;
			interval_time <= res_interval;
			total_time    <= res_total;
		end
	end

	assign out_valid = out_valid_q;

	`CSET_ASSERT(a_no_pop_in_clear, !(clearing && q_pop), "queue drained during clear")
	`CSET_ASSERT_NEXT(a_dur_then_exc, state_q == cset_pkg::B_DUR,
		state_q == cset_pkg::B_EXC, "close sequence broken")
	`CSET_ASSERT(a_interval_le_dur, (state_q != cset_pkg::B_TOT) || (interval_q <= dur_q),
		"exclusive time above duration")

endmodule

### design/call_stack_exclusive_time.sv
// Call stack exclusive time: per-function exclusive time from start/end/read trace words.
// Each accepted word gives one result word. The front end classifies a word in the cycle it
// is taken and tracks the stack level, so a word enters a two-entry queue whenever the queue
// has room; the back end then works one command at a time against small stack and
// total memories with registered reads: a start or a read goes through memory read and
// result, an end through memory read, duration, exclusive time and caller update, total
// update and result, each after the queue. A finished result waits in the output register
// while the back end starts the next word. After reset the back end clears the total table,
// one entry a cycle, over all NUM_FUNCS entries, and no word is taken until that is done.
module call_stack_exclusive_time #(
	parameter int NUM_FUNCS   = cset_pkg::NUM_FUNCS_DEF,
	parameter int STACK_DEPTH = cset_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  operation,
	input  logic [cset_pkg::FID_W-1:0]  function_id,
	input  logic [cset_pkg::TS_W-1:0]   timestamp,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  status,
	output logic [cset_pkg::FID_W-1:0]  function_out,
	output logic [cset_pkg::TS_W-1:0]   interval_time,
	output logic [cset_pkg::TS_W-1:0]   total_time
);

	localparam int SA = $clog2(STACK_DEPTH);
	localparam int QW = $bits(cset_pkg::cmd_t) + SA;

	cset_pkg::cmd_t front_cmd, q_cmd;
	logic [SA-1:0]  front_idx, q_idx;
	logic [QW-1:0]  q_dout;
	logic           q_push, q_pop, q_full, q_empty, clearing;

	cset_front #(
		.NUM_FUNCS   (NUM_FUNCS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.function_id (function_id),
		.timestamp   (timestamp),
		.q_full      (q_full),
		.clearing    (clearing),
		.q_push      (q_push),
		.cmd         (front_cmd),
		.idx         (front_idx)
	);

	cset_queue #(
		.WIDTH (QW)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    ({front_cmd, front_idx}),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_dout),
		.empty  (q_empty)
	);

	assign {q_cmd, q_idx} = q_dout;

	cset_back #(
		.NUM_FUNCS   (NUM_FUNCS),
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_cmd         (q_cmd),
		.q_idx         (q_idx),
		.q_empty       (q_empty),
		.q_pop         (q_pop),
		.clearing      (clearing),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.function_out  (function_out),
		.interval_time (interval_time),
		.total_time    (total_time)
	);

endmodule
